FILE: sv/crfr_pkg.sv
// ----------------------------------------------------------------------------
// crfr_pkg
// Types, codes and the CRC-16/CCITT-FALSE byte update shared by the frame
// receiver modules.
// ----------------------------------------------------------------------------
package crfr_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'hA5;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] TICK_MAX  = 16'hFFFF;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic REG_MAX_PAYLOAD   = 1'b0;
	localparam logic REG_TIMEOUT_TICKS = 1'b1;

	localparam logic [10:0] MAX_PAYLOAD_RST   = 11'd1024;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_ID      = 3'd1,
		PH_LEN_HI  = 3'd2,
		PH_LEN_LO  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CRC_HI  = 3'd5,
		PH_CRC_LO  = 3'd6,
		PH_END     = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_ACCEPT  = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_TIMEOUT = 3'd0,
		ERR_START   = 3'd1,
		ERR_SIZE    = 3'd2,
		ERR_CRC     = 3'd3,
		ERR_END     = 3'd4
	} err_t;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
		logic       is_flag;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [9:0]  payload_index;
		logic [7:0]  frame_id;
		logic [10:0] frame_length;
		err_t        error_code;
	} result_t;

	typedef struct packed {
		logic [10:0] max_payload;
		logic [15:0] timeout_ticks;
	} cfg_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: sv/crc_checked_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver
// Flag-delimited frame receiver with CRC-16/CCITT-FALSE check: reports
// payload bytes as they arrive, then frame accept or a frame error.
// ----------------------------------------------------------------------------
//  channel   handshake       payload
//  -------   -------------   ------------------------------------------------
//  input     push / full     func, rx_byte
//  result    empty / pop     kind, payload_byte, payload_index, frame_id,
//                            frame_length, error_code
//  config    cfg_we          cfg_addr, cfg_wdata
//
//  one word per cycle sustained in both directions while the result queue has room
//  a result word reaches the result port by way of the input queue, then
//  the parser into the result queue
//  the parser stalls only when the two-entry result queue is full
//  reset clears both queues and returns the parser to hunting
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver #(
	parameter int unsigned PAYLOAD_LIMIT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        func,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [9:0]  payload_index,
	output logic [7:0]  frame_id,
	output logic [10:0] frame_length,
	output logic [2:0]  error_code,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata
);

	crfr_pkg::cfg_t    cfg_q;
	logic              item_valid;
	crfr_pkg::item_t   item;
	logic              item_take;
	logic              res_full;
	logic              res_valid;
	crfr_pkg::result_t res;
	crfr_pkg::result_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload   <= crfr_pkg::MAX_PAYLOAD_RST;
			cfg_q.timeout_ticks <= crfr_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				crfr_pkg::REG_MAX_PAYLOAD:   cfg_q.max_payload   <= cfg_wdata[10:0];
				crfr_pkg::REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	crfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.func       (func),
		.rx_byte    (rx_byte),
		.full       (full),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	crfr_back #(
		.PAYLOAD_LIMIT (PAYLOAD_LIMIT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_full   (res_full),
		.res_valid  (res_valid),
		.res        (res)
	);

	crfr_out_q u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_full  (res_full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	assign kind          = head.kind;
	assign payload_byte  = head.payload_byte;
	assign payload_index = head.payload_index;
	assign frame_id      = head.frame_id;
	assign frame_length  = head.frame_length;
	assign error_code    = head.error_code;

endmodule

FILE: sv/crfr_front.sv
// ----------------------------------------------------------------------------
// crfr_front
// Input side: takes words, marks every byte equal to the flag byte, and holds
// them in a two-entry queue for the parser.
// ----------------------------------------------------------------------------
module crfr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 func,
	input  logic [7:0]           rx_byte,
	output logic                 full,
	output logic                 item_valid,
	output crfr_pkg::item_t      item,
	input  logic                 item_take
);

	crfr_pkg::item_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            do_push;
	logic            do_pop;
	crfr_pkg::item_t new_item;

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;
	assign item       = mem_q[rd_ptr_q];

	always_comb begin
		new_item.func    = func;
		new_item.rx_byte = rx_byte;
		new_item.is_flag = (rx_byte == crfr_pkg::FLAG_BYTE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

FILE: sv/crfr_back.sv
// ----------------------------------------------------------------------------
// crfr_back
// Frame parser: walks the frame fields, keeps the running CRC and the tick
// count, and produces payload, accept and error words.
// ----------------------------------------------------------------------------
module crfr_back #(
	parameter int unsigned PAYLOAD_LIMIT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crfr_pkg::cfg_t       cfg,
	input  logic                 item_valid,
	input  crfr_pkg::item_t      item,
	output logic                 item_take,
	input  logic                 res_full,
	output logic                 res_valid,
	output crfr_pkg::result_t    res
);

	localparam int unsigned LEN_CAP = (PAYLOAD_LIMIT < 2047) ? PAYLOAD_LIMIT : 2047;
	localparam int unsigned LEN_W   = $clog2(LEN_CAP + 1);
	localparam logic [15:0] LIMIT16 = 16'(PAYLOAD_LIMIT);

	crfr_pkg::phase_t phase_q, phase_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       len_hi_q, len_hi_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] taken_q, taken_d;
	logic [7:0]       crc_hi_q, crc_hi_d;
	logic [7:0]       crc_lo_q, crc_lo_d;
	logic [7:0]       id_q, id_d;
	logic [15:0]      wait_q, wait_d;

	logic [15:0]      crc_nxt;
	logic [15:0]      len16;
	logic [15:0]      limit;
	logic [15:0]      wait_inc;
	logic [LEN_W-1:0] taken_inc;

	assign item_take = item_valid && !res_full;
	assign crc_nxt   = crfr_pkg::crc_byte(crc_q, item.rx_byte);
	assign len16     = {len_hi_q, item.rx_byte};
	assign limit     = (16'(cfg.max_payload) < LIMIT16) ? 16'(cfg.max_payload) : LIMIT16;
	assign wait_inc  = (wait_q == crfr_pkg::TICK_MAX) ? wait_q : wait_q + 16'd1;
	assign taken_inc = taken_q + LEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= crfr_pkg::PH_HUNT;
			crc_q    <= crfr_pkg::CRC_INIT;
			len_hi_q <= 8'd0;
			len_q    <= '0;
			taken_q  <= '0;
			crc_hi_q <= 8'd0;
			crc_lo_q <= 8'd0;
			id_q     <= 8'd0;
			wait_q   <= 16'd0;
		end else begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			len_hi_q <= len_hi_d;
			len_q    <= len_d;
			taken_q  <= taken_d;
			crc_hi_q <= crc_hi_d;
			crc_lo_q <= crc_lo_d;
			id_q     <= id_d;
			wait_q   <= wait_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		crc_d     = crc_q;
		len_hi_d  = len_hi_q;
		len_d     = len_q;
		taken_d   = taken_q;
		crc_hi_d  = crc_hi_q;
		crc_lo_d  = crc_lo_q;
		id_d      = id_q;
		wait_d    = wait_q;
		res_valid = 1'b0;
		res       = '0;
		res.frame_id = id_q;

		if (item_take) begin
			if (item.func == crfr_pkg::FUNC_TICK) begin
				if (phase_q != crfr_pkg::PH_HUNT) begin
					wait_d = wait_inc;
					if (wait_inc > cfg.timeout_ticks) begin
						res_valid      = 1'b1;
						res.kind       = crfr_pkg::KIND_ERROR;
						res.error_code = crfr_pkg::ERR_TIMEOUT;
						phase_d        = crfr_pkg::PH_HUNT;
						wait_d         = 16'd0;
					end
				end
			end else begin
				unique case (phase_q)
					crfr_pkg::PH_HUNT: begin
						if (!item.is_flag) begin
							res_valid      = 1'b1;
							res.kind       = crfr_pkg::KIND_ERROR;
							res.error_code = crfr_pkg::ERR_START;
							res.frame_id   = 8'd0;
						end else begin
							phase_d  = crfr_pkg::PH_ID;
							crc_d    = crfr_pkg::CRC_INIT;
							len_hi_d = 8'd0;
							len_d    = '0;
							taken_d  = '0;
							crc_hi_d = 8'd0;
							crc_lo_d = 8'd0;
							id_d     = 8'd0;
							wait_d   = 16'd0;
						end
					end
					crfr_pkg::PH_ID: begin
						id_d    = item.rx_byte;
						crc_d   = crc_nxt;
						phase_d = crfr_pkg::PH_LEN_HI;
					end
					crfr_pkg::PH_LEN_HI: begin
						len_hi_d = item.rx_byte;
						crc_d    = crc_nxt;
						phase_d  = crfr_pkg::PH_LEN_LO;
					end
					crfr_pkg::PH_LEN_LO: begin
						crc_d = crc_nxt;
						if (len16 > limit) begin
							res_valid      = 1'b1;
							res.kind       = crfr_pkg::KIND_ERROR;
							res.error_code = crfr_pkg::ERR_SIZE;
							phase_d        = crfr_pkg::PH_HUNT;
							wait_d         = 16'd0;
						end else begin
							len_d   = LEN_W'(len16);
							taken_d = '0;
							phase_d = (len16 == 16'd0) ? crfr_pkg::PH_CRC_HI
							                           : crfr_pkg::PH_PAYLOAD;
						end
					end
					crfr_pkg::PH_PAYLOAD: begin
						crc_d             = crc_nxt;
						res_valid         = 1'b1;
						res.kind          = crfr_pkg::KIND_PAYLOAD;
						res.payload_byte  = item.rx_byte;
						res.payload_index = 10'(taken_q);
						taken_d           = taken_inc;
						if (taken_inc == len_q) begin
							phase_d = crfr_pkg::PH_CRC_HI;
						end
					end
					crfr_pkg::PH_CRC_HI: begin
						crc_hi_d = item.rx_byte;
						phase_d  = crfr_pkg::PH_CRC_LO;
					end
					crfr_pkg::PH_CRC_LO: begin
						crc_lo_d = item.rx_byte;
						phase_d  = crfr_pkg::PH_END;
					end
					crfr_pkg::PH_END: begin
						res_valid = 1'b1;
						phase_d   = crfr_pkg::PH_HUNT;
						wait_d    = 16'd0;
						if ({crc_hi_q, crc_lo_q} != crc_q) begin
							res.kind       = crfr_pkg::KIND_ERROR;
							res.error_code = crfr_pkg::ERR_CRC;
						end else if (!item.is_flag) begin
							res.kind       = crfr_pkg::KIND_ERROR;
							res.error_code = crfr_pkg::ERR_END;
						end else begin
							res.kind         = crfr_pkg::KIND_ACCEPT;
							res.frame_length = 11'(len_q);
						end
					end
					default: begin
						phase_d = crfr_pkg::PH_HUNT;
					end
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_payload_in_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == crfr_pkg::KIND_PAYLOAD |-> phase_q == crfr_pkg::PH_PAYLOAD)
		else $error("payload word outside payload phase");

	a_hunt_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == crfr_pkg::PH_HUNT |-> wait_q == 16'd0)
		else $error("tick count not cleared while hunting");

	a_taken_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == crfr_pkg::PH_PAYLOAD |-> taken_q < len_q)
		else $error("payload count past length");

	a_accept_crc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == crfr_pkg::KIND_ACCEPT |-> crc_q == {crc_hi_q, crc_lo_q})
		else $error("frame accepted with crc mismatch");

	a_word_needs_take: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> item_take && !res_full)
		else $error("word produced without a taken item");
`endif

endmodule

FILE: sv/crfr_out_q.sv
// ----------------------------------------------------------------------------
// crfr_out_q
// Two-entry result queue between the parser and the result port.
// ----------------------------------------------------------------------------
module crfr_out_q (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_valid,
	input  crfr_pkg::result_t    res,
	output logic                 res_full,
	input  logic                 pop,
	output logic                 empty,
	output crfr_pkg::result_t    head
);

	crfr_pkg::result_t mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              do_push;
	logic              do_pop;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign do_push  = res_valid && !res_full;
	assign do_pop   = pop && !empty;
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

endmodule

FILE: bench/crc_checked_frame_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_tb
// Drives byte and tick words into the frame receiver, predicts every result
// word (payload, accept, error) with an independent deframer model and
// compares each popped word field by field, under random push/pop idling
// and a series of register settings.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver_tb;

	localparam int PAYLOAD_LIMIT = 1024;
	localparam int CYCLE_LIMIT   = 20000;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic        func      = 1'b0;
	logic [7:0]  rx_byte   = 8'h00;
	logic        pop       = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_addr  = 1'b0;
	logic [15:0] cfg_wdata = 16'h0000;
	logic        full;
	logic        empty;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [9:0]  payload_index;
	logic [7:0]  frame_id;
	logic [10:0] frame_length;
	logic [2:0]  error_code;

	crc_checked_frame_receiver #(
		.PAYLOAD_LIMIT(PAYLOAD_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.func(func),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.frame_id(frame_id),
		.frame_length(frame_length),
		.error_code(error_code),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// deframer model state
	crfr_pkg::phase_t rx_phase        = crfr_pkg::PH_HUNT;
	logic [15:0]      crc_acc         = crfr_pkg::CRC_INIT;
	logic [15:0]      len_field       = 16'h0000;
	logic [10:0]      pay_count       = 11'd0;
	logic [15:0]      crc_field       = 16'h0000;
	logic [7:0]       id_byte         = 8'h00;
	logic [15:0]      tick_count      = 16'h0000;
	logic [10:0]      cfg_max_payload = crfr_pkg::MAX_PAYLOAD_RST;
	logic [15:0]      cfg_timeout     = crfr_pkg::TIMEOUT_TICKS_RST;

	crfr_pkg::result_t expected_words[$];
	int                mismatches  = 0;
	int                words_sent  = 0;
	int                cycle_count = 0;
	bit                calm        = 1'b0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	task automatic frame_error(input crfr_pkg::err_t code, output crfr_pkg::result_t r);
		r = '0;
		r.kind = crfr_pkg::KIND_ERROR;
		r.frame_id = id_byte;
		r.error_code = code;
		rx_phase = crfr_pkg::PH_HUNT;
		tick_count = 16'h0000;
	endtask

	task automatic predict_word(input logic f, input logic [7:0] b);
		crfr_pkg::result_t r;
		bit                hit;
		int                lim;
		r = '0;
		hit = 1'b0;
		lim = (cfg_max_payload < PAYLOAD_LIMIT) ? cfg_max_payload : PAYLOAD_LIMIT;
		if (f == crfr_pkg::FUNC_TICK) begin
			if (rx_phase != crfr_pkg::PH_HUNT) begin
				if (tick_count != crfr_pkg::TICK_MAX) tick_count++;
				if (tick_count > cfg_timeout) begin
					frame_error(crfr_pkg::ERR_TIMEOUT, r);
					hit = 1'b1;
				end
			end
		end else begin
			case (rx_phase)
				crfr_pkg::PH_HUNT: begin
					if (b != crfr_pkg::FLAG_BYTE) begin
						r.kind = crfr_pkg::KIND_ERROR;
						r.error_code = crfr_pkg::ERR_START;
						hit = 1'b1;
					end else begin
						rx_phase = crfr_pkg::PH_ID;
						crc_acc = crfr_pkg::CRC_INIT;
						len_field = 16'h0000;
						pay_count = 11'd0;
						crc_field = 16'h0000;
						id_byte = 8'h00;
						tick_count = 16'h0000;
					end
				end
				crfr_pkg::PH_ID: begin
					id_byte = b;
					crc_acc = crc_next(crc_acc, b);
					rx_phase = crfr_pkg::PH_LEN_HI;
				end
				crfr_pkg::PH_LEN_HI: begin
					len_field = {b, 8'h00};
					crc_acc = crc_next(crc_acc, b);
					rx_phase = crfr_pkg::PH_LEN_LO;
				end
				crfr_pkg::PH_LEN_LO: begin
					len_field = {len_field[15:8], b};
					crc_acc = crc_next(crc_acc, b);
					if (int'(len_field) > lim) begin
						frame_error(crfr_pkg::ERR_SIZE, r);
						hit = 1'b1;
					end else begin
						pay_count = 11'd0;
						rx_phase = (len_field == 16'h0000) ? crfr_pkg::PH_CRC_HI
							: crfr_pkg::PH_PAYLOAD;
					end
				end
				crfr_pkg::PH_PAYLOAD: begin
					crc_acc = crc_next(crc_acc, b);
					r.kind = crfr_pkg::KIND_PAYLOAD;
					r.payload_byte = b;
					r.payload_index = pay_count[9:0];
					r.frame_id = id_byte;
					hit = 1'b1;
					pay_count++;
					if (pay_count >= len_field) rx_phase = crfr_pkg::PH_CRC_HI;
				end
				crfr_pkg::PH_CRC_HI: begin
					crc_field = {b, 8'h00};
					rx_phase = crfr_pkg::PH_CRC_LO;
				end
				crfr_pkg::PH_CRC_LO: begin
					crc_field = {crc_field[15:8], b};
					rx_phase = crfr_pkg::PH_END;
				end
				default: begin
					hit = 1'b1;
					if (crc_field != crc_acc) begin
						frame_error(crfr_pkg::ERR_CRC, r);
					end else if (b != crfr_pkg::FLAG_BYTE) begin
						frame_error(crfr_pkg::ERR_END, r);
					end else begin
						r.kind = crfr_pkg::KIND_ACCEPT;
						r.frame_id = id_byte;
						r.frame_length = len_field[10:0];
						rx_phase = crfr_pkg::PH_HUNT;
						tick_count = 16'h0000;
					end
				end
			endcase
		end
		if (hit) expected_words.insert(expected_words.size(), r);
	endtask

	task automatic report(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	always @(negedge clk) begin
		pop <= calm || ($urandom_range(0, 99) >= 26);
	end

	always @(posedge clk) begin
		crfr_pkg::result_t want;
		if (arst_n && !empty && pop) begin
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word, kind %0d", kind));
			end else begin
				want = expected_words.pop_front();
				if (kind !== want.kind)
					report($sformatf("kind %0d, want %0d", kind, want.kind));
				if (payload_byte !== want.payload_byte)
					report($sformatf("payload_byte %0h, want %0h", payload_byte,
						want.payload_byte));
				if (payload_index !== want.payload_index)
					report($sformatf("payload_index %0d, want %0d", payload_index,
						want.payload_index));
				if (frame_id !== want.frame_id)
					report($sformatf("frame_id %0h, want %0h", frame_id, want.frame_id));
				if (frame_length !== want.frame_length)
					report($sformatf("frame_length %0d, want %0d", frame_length,
						want.frame_length));
				if (error_code !== want.error_code)
					report($sformatf("error_code %0d, want %0d", error_code,
						want.error_code));
			end
		end
	end

	task automatic send_word(input logic f, input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 26) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		func <= f;
		rx_byte <= b;
		do @(posedge clk); while (full);
		predict_word(f, b);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic tick_maybe(input int pct);
		if ($urandom_range(0, 99) < pct) send_word(crfr_pkg::FUNC_TICK, 8'($urandom));
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_config(input logic [15:0] max_val, input logic [15:0] tmo_val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_addr <= crfr_pkg::REG_MAX_PAYLOAD;
		cfg_wdata <= max_val;
		@(negedge clk);
		cfg_addr <= crfr_pkg::REG_TIMEOUT_TICKS;
		cfg_wdata <= tmo_val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		cfg_max_payload = max_val[10:0];
		cfg_timeout = tmo_val;
	endtask

	task automatic send_header(input logic [7:0] id, input logic [15:0] len, input int pct,
			output logic [15:0] crc);
		send_word(crfr_pkg::FUNC_BYTE, crfr_pkg::FLAG_BYTE);
		tick_maybe(pct);
		send_word(crfr_pkg::FUNC_BYTE, id);
		tick_maybe(pct);
		send_word(crfr_pkg::FUNC_BYTE, len[15:8]);
		tick_maybe(pct);
		send_word(crfr_pkg::FUNC_BYTE, len[7:0]);
		tick_maybe(pct);
		crc = crc_next(crc_next(crc_next(crfr_pkg::CRC_INIT, id), len[15:8]), len[7:0]);
	endtask

	task automatic send_frame(input logic [7:0] id, input logic [15:0] len,
			input bit rand_payload, input logic [15:0] crc_flip,
			input logic [7:0] end_byte, input int pct);
		logic [15:0] crc;
		logic [7:0]  b;
		int          i;
		send_header(id, len, pct, crc);
		for (i = 0; i < len; i++) begin
			b = rand_payload ? 8'($urandom) : 8'(i);
			crc = crc_next(crc, b);
			send_word(crfr_pkg::FUNC_BYTE, b);
			tick_maybe(pct);
		end
		crc = crc ^ crc_flip;
		send_word(crfr_pkg::FUNC_BYTE, crc[15:8]);
		tick_maybe(pct);
		send_word(crfr_pkg::FUNC_BYTE, crc[7:0]);
		tick_maybe(pct);
		send_word(crfr_pkg::FUNC_BYTE, end_byte);
	endtask

	task automatic test_stray_bytes();
		send_word(crfr_pkg::FUNC_BYTE, 8'h00);
		send_word(crfr_pkg::FUNC_BYTE, 8'hFF);
		send_word(crfr_pkg::FUNC_BYTE, 8'h5A);
		// ticks while hunting are dropped
		send_word(crfr_pkg::FUNC_TICK, 8'hFF);
		send_word(crfr_pkg::FUNC_TICK, 8'h00);
		send_frame(8'h00, 16'd0, 1'b0, 16'h0000, crfr_pkg::FLAG_BYTE, 0);
	endtask

	task automatic test_good_frames();
		send_frame(8'hFF, 16'd3, 1'b0, 16'h0000, crfr_pkg::FLAG_BYTE, 0);
		send_frame(8'h3C, 16'd260, 1'b0, 16'h0000, crfr_pkg::FLAG_BYTE, 0);
	endtask

	task automatic test_end_checks();
		send_frame(8'h12, 16'd2, 1'b1, 16'h8000, crfr_pkg::FLAG_BYTE, 0);
		// end byte of a failed frame never opens a new one
		send_word(crfr_pkg::FUNC_BYTE, 8'h11);
		send_frame(8'h34, 16'd1, 1'b1, 16'h0001, 8'h00, 0);
		send_frame(8'h56, 16'd0, 1'b1, 16'h0000, 8'h5A, 0);
	endtask

	task automatic test_size_limits();
		logic [15:0] crc;
		set_config(16'd0, 16'd1000);
		send_header(8'h01, 16'd1, 0, crc);
		send_frame(8'h02, 16'd0, 1'b1, 16'h0000, crfr_pkg::FLAG_BYTE, 0);
		// upper bits dropped, limit falls back to the payload limit
		set_config(16'hFFFF, 16'd1000);
		send_header(8'h03, 16'd1025, 0, crc);
		send_header(8'h04, 16'hFFFF, 0, crc);
		send_frame(8'h05, 16'd2, 1'b1, 16'h0000, crfr_pkg::FLAG_BYTE, 0);
	endtask

	task automatic test_timeouts();
		set_config(16'd1024, 16'd0);
		send_word(crfr_pkg::FUNC_BYTE, crfr_pkg::FLAG_BYTE);
		send_word(crfr_pkg::FUNC_TICK, 8'h00);
		send_word(crfr_pkg::FUNC_TICK, 8'h00);
		set_config(16'd1024, 16'd3);
		send_word(crfr_pkg::FUNC_BYTE, crfr_pkg::FLAG_BYTE);
		send_word(crfr_pkg::FUNC_BYTE, 8'h77);
		repeat (3) send_word(crfr_pkg::FUNC_TICK, 8'h00);
		send_word(crfr_pkg::FUNC_BYTE, 8'h00);
		send_word(crfr_pkg::FUNC_TICK, 8'h00);
	endtask

	task automatic test_random_traffic();
		logic [15:0] crc;
		logic [15:0] max_val;
		logic [15:0] tmo_val;
		logic [7:0]  id;
		int          pick;
		int          lim;
		int          len;
		int          over;
		int          goal;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin max_val = 16'hFFFF; tmo_val = 16'd1000; end
				1: begin max_val = 16'd0; tmo_val = 16'hFFFF; end
				2: begin
					max_val = {5'($urandom), 11'($urandom_range(1, 20))};
					tmo_val = 16'($urandom_range(0, 15));
				end
				3: begin max_val = 16'd1024; tmo_val = 16'd0; end
				4: begin
					max_val = 16'($urandom_range(0, 40));
					tmo_val = 16'($urandom);
				end
				default: begin
					max_val = 16'($urandom_range(1, 1024));
					tmo_val = 16'($urandom_range(3, 30));
				end
			endcase
			set_config(max_val, tmo_val);
			calm = (ph == 0);
			goal = words_sent + 60;
			while (words_sent < goal) begin
				pick = $urandom_range(0, 99);
				lim = (cfg_max_payload < PAYLOAD_LIMIT) ? cfg_max_payload : PAYLOAD_LIMIT;
				id = 8'($urandom);
				len = $urandom_range(0, (lim < 12) ? lim : 12);
				if (pick < 70) begin
					send_frame(id, 16'(len), 1'b1, 16'h0000, crfr_pkg::FLAG_BYTE, 8);
				end else if (pick < 77) begin
					send_frame(id, 16'(len), 1'b1, 16'(1 << $urandom_range(0, 15)),
						crfr_pkg::FLAG_BYTE, 8);
				end else if (pick < 83) begin
					send_frame(id, 16'(len), 1'b1, 16'h0000,
						crfr_pkg::FLAG_BYTE ^ 8'($urandom_range(1, 255)), 8);
				end else if (pick < 88) begin
					over = (lim >= PAYLOAD_LIMIT) ? $urandom_range(PAYLOAD_LIMIT + 1, 65535)
						: lim + $urandom_range(1, 3);
					if ($urandom_range(0, 3) == 0) over = 65535;
					send_header(id, 16'(over), 8, crc);
				end else if (pick < 94) begin
					repeat ($urandom_range(1, 4)) send_word(1'($urandom), 8'($urandom));
				end else begin
					// truncated frame, whatever follows is parsed as its tail
					send_header(id, 16'(len), 8, crc);
					repeat ($urandom_range(0, 2))
						send_word(crfr_pkg::FUNC_BYTE, 8'($urandom));
				end
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_stray_bytes();
		test_good_frames();
		test_end_checks();
		test_size_limits();
		test_timeouts();
		test_random_traffic();
		wait_idle();
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/crfr_pkg.sv
sv/crfr_front.sv
sv/crfr_back.sv
sv/crfr_out_q.sv
sv/crc_checked_frame_receiver.sv
bench/crc_checked_frame_receiver_tb.sv
